[hdl/i2c_master_transaction_unit_macros.svh]
// ============================================================================
// I2C master transaction unit - assertion macros
// Short forms for the clocked, reset-gated properties used by the checker.
// ============================================================================
`ifndef I2C_MASTER_TRANSACTION_UNIT_MACROS_SVH
`define I2C_MASTER_TRANSACTION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define IMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/imt_pkg.sv]
// ============================================================================
// I2C master transaction unit - package
// Shared types, bus phase encoding and constants.
// ============================================================================
package imt_pkg;

    localparam int IMT_BUFFER_DEPTH = 16;

    localparam logic [7:0] IMT_UNIT_TICKS_RESET = 8'd1;
    localparam logic [7:0] IMT_READ_BIT         = 8'h01;
    localparam logic [7:0] IMT_ADDR_MASK        = 8'hFE;
    localparam logic [7:0] IMT_MSB_MASK         = 8'h80;
    localparam logic [3:0] IMT_BITS_PER_BYTE    = 4'd8;

    // Command codes carried by a request.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // Bus sequencing phases. Each phase but idle lasts one delay unit.
    typedef enum logic [4:0] {
        PH_IDLE, PH_S0, PH_S1, PH_S2,
        PH_B0, PH_B1, PH_B2,
        PH_A0, PH_A1, PH_A2, PH_A3, PH_A4, PH_A5,
        PH_R0A, PH_R0B, PH_R1A, PH_R1B,
        PH_Q0, PH_Q1, PH_P0, PH_P1
    } t_phase;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] device_address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_in;
    } t_req;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       busy_res;
        logic       nack_abort;
        logic       done_res;
    } t_res;

    // Classified request as held in the queue.
    typedef struct packed {
        t_cmd       kind;
        logic [7:0] address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_in;
    } t_op;

endpackage

[hdl/i2c_master_transaction_unit.sv]
// ============================================================================
// I2C master transaction unit - top level
// Request-driven I2C master sequencer with a write buffer and bit timing.
// ============================================================================
// Usage: every request on the i_req channel (valid/ready) yields exactly one
// result on the o_res channel, in order. Requests carry a command: a tick
// advances bus time by one tick, load appends a byte to the write buffer,
// and start write / start read launch a transaction. While a transaction runs
// only ticks have an effect; other commands still produce a result.
// The single configuration register (ticks per delay unit) is written by the
// user via i_cfg_we / i_cfg_wdata only while the unit is idle; not enforced.
// Result path: an accepted request is registered into the queue; the engine
// then takes it and registers its result in the result register, which
// drives o_res. A full result register can hold a request in the queue.
// Throughput: one request per cycle, set by the engine step;
// the two-entry queue and the result register keep that rate while both
// sides are ready.
// Stalls: if the receiver holds i_res_ready low, the result register holds,
// the queue fills, and then o_req_ready drops until a result is taken.
// Reset (synchronous, active low) idles the sequencer, empties the buffer,
// drives SCL and SDA high, and loads ticks per unit with one. Buffer
// contents are not cleared; only loaded entries are ever read.
// ============================================================================
module i2c_master_transaction_unit
    import imt_pkg::*;
#(
    parameter int BUFFER_DEPTH = IMT_BUFFER_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_req       i_req,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_res       o_res,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    // Front end to queue.
    logic q_push;
    logic q_ready;
    t_op  push_op;

    // Queue to engine.
    logic q_valid;
    logic q_pop;
    t_op  head_op;

    imt_front u_front (
        .i_req_valid   (i_req_valid),
        .o_req_ready   (o_req_ready),
        .i_req         (i_req),
        .i_queue_ready (q_ready),
        .o_push        (q_push),
        .o_op          (push_op)
    );

    // Decouples request acceptance from the engine's result back-pressure.
    imt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    // The engine takes one queued request whenever its result register is
    // free or being drained this cycle.
    imt_engine #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op_valid  (q_valid),
        .i_op        (head_op),
        .o_pop       (q_pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

endmodule

[hdl/imt_front.sv]
// ============================================================================
// I2C master transaction unit - front end
// Accepts requests, decodes the command and applies the direction bit.
// ============================================================================
module imt_front
    import imt_pkg::*;
(
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    input  logic i_queue_ready,
    output logic o_push,
    output t_op  o_op
);

    t_cmd cmd;

    always_comb begin
        cmd = t_cmd'(i_req.command);
        o_op.kind       = cmd;
        o_op.byte_count = i_req.byte_count;
        o_op.write_byte = i_req.write_byte;
        o_op.sda_in     = i_req.sda_in;
        // The direction bit replaces bit 0 of the address byte.
        if (cmd == CMD_READ) begin
            o_op.address = i_req.device_address | IMT_READ_BIT;
        end else begin
            o_op.address = i_req.device_address & IMT_ADDR_MASK;
        end
    end

    assign o_req_ready = i_queue_ready;
    assign o_push      = i_req_valid && i_queue_ready;

endmodule

[hdl/imt_queue.sv]
// ============================================================================
// I2C master transaction unit - request queue
// Two-entry queue between the front end and the bus engine.
// ============================================================================
module imt_queue
    import imt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_op
);

    t_op        r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[hdl/imt_engine.sv]
// ============================================================================
// I2C master transaction unit - bus engine
// Runs the SCL/SDA phase sequencer, the write buffer and the result register.
// ============================================================================
module imt_engine
    import imt_pkg::*;
#(
    parameter int BUFFER_DEPTH = IMT_BUFFER_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_op_valid,
    input  t_op        i_op,
    output logic       o_pop,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_res       o_res
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_DEPTH);

    logic [7:0]    r_store [BUFFER_DEPTH];
    logic [7:0]    r_rd_data;

    logic [7:0]    r_unit_ticks;
    t_phase        r_phase,     n_phase;
    logic [3:0]    r_bit,       n_bit;
    logic [7:0]    r_bytepos,   n_bytepos;
    logic [7:0]    r_shift,     n_shift;
    logic [7:0]    r_unit,      n_unit;
    logic [FW-1:0] r_fill,      n_fill;
    logic [7:0]    r_addr,      n_addr;
    logic [7:0]    r_target,    n_target;
    logic          r_reading,   n_reading;
    logic          r_scl,       n_scl;
    logic          r_sda,       n_sda;
    logic          r_drive,     n_drive;
    logic [7:0]    r_last_read, n_last_read;
    logic          r_nack,      n_nack;
    logic          n_read_valid;
    logic          n_done;
    logic          store_we;

    logic          r_res_valid;
    t_res          r_res,       n_res;

    logic          take;
    logic [7:0]    lim;
    logic [7:0]    unit_inc;
    logic [3:0]    bit_inc;
    logic [7:0]    byte_inc;
    logic [7:0]    fill_ext;
    logic [7:0]    rx_shift;

    assign take     = i_op_valid && (!r_res_valid || i_res_ready);
    assign o_pop    = take;
    assign lim      = (r_unit_ticks != 8'd0) ? r_unit_ticks : 8'd1;
    assign unit_inc = r_unit + 8'd1;
    assign bit_inc  = r_bit + 4'd1;
    assign byte_inc = r_bytepos + 8'd1;
    assign fill_ext = 8'(r_fill);
    assign rx_shift = {r_shift[6:0], i_op.sda_in};

    // Next state of the sequencer and its datapath.
    always_comb begin
        n_phase      = r_phase;
        n_bit        = r_bit;
        n_bytepos    = r_bytepos;
        n_shift      = r_shift;
        n_unit       = r_unit;
        n_fill       = r_fill;
        n_addr       = r_addr;
        n_target     = r_target;
        n_reading    = r_reading;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_drive      = r_drive;
        n_last_read  = r_last_read;
        n_nack       = r_nack;
        n_read_valid = 1'b0;
        n_done       = 1'b0;
        store_we     = 1'b0;

        if (take) begin
            if (r_phase != PH_IDLE) begin
                if (i_op.kind == CMD_TICK) begin
                    n_unit = unit_inc;
                    if (unit_inc >= lim) begin
                        n_unit = 8'd0;
                        case (r_phase)
                            PH_S0: begin
                                n_phase = PH_S1;
                                n_sda   = 1'b0;
                            end
                            PH_S1: begin
                                n_phase = PH_S2;
                                n_scl   = 1'b0;
                            end
                            PH_S2: begin
                                n_shift = r_addr;
                                n_bit   = 4'd0;
                                n_phase = PH_B0;
                                n_scl   = 1'b0;
                            end
                            PH_B0: begin
                                n_phase = PH_B1;
                                n_drive = 1'b1;
                                n_sda   = |(r_shift & IMT_MSB_MASK);
                            end
                            PH_B1: begin
                                n_phase = PH_B2;
                                n_scl   = 1'b1;
                            end
                            PH_B2: begin
                                n_shift = {r_shift[6:0], 1'b0};
                                n_bit   = bit_inc;
                                n_scl   = 1'b0;
                                n_phase = (bit_inc >= IMT_BITS_PER_BYTE) ? PH_A0 : PH_B0;
                            end
                            PH_A0: begin
                                n_phase = PH_A1;
                                n_drive = 1'b0;
                            end
                            PH_A1: begin
                                n_phase = PH_A2;
                                n_scl   = 1'b1;
                            end
                            PH_A2: begin
                                n_phase = PH_A3;
                            end
                            PH_A3: begin
                                if (i_op.sda_in) begin
                                    n_nack = 1'b1;
                                end
                                n_phase = PH_A4;
                                n_scl   = 1'b0;
                            end
                            PH_A4: begin
                                n_phase = PH_A5;
                                n_scl   = 1'b0;
                                n_sda   = 1'b0;
                                n_drive = 1'b1;
                            end
                            PH_A5: begin
                                if (r_nack) begin
                                    n_phase = PH_P0;
                                    n_scl   = 1'b0;
                                    n_sda   = 1'b0;
                                    n_drive = 1'b1;
                                end else if (r_reading) begin
                                    if (r_bytepos >= r_target) begin
                                        n_phase = PH_Q0;
                                        n_scl   = 1'b0;
                                        n_sda   = 1'b1;
                                        n_drive = 1'b1;
                                    end else begin
                                        n_bit   = 4'd0;
                                        n_shift = 8'd0;
                                        n_phase = PH_R0A;
                                        n_scl   = 1'b0;
                                        n_drive = 1'b0;
                                    end
                                end else if (r_bytepos < r_target && r_bytepos < fill_ext) begin
                                    n_shift   = r_rd_data;
                                    n_bytepos = byte_inc;
                                    n_bit     = 4'd0;
                                    n_phase   = PH_B0;
                                    n_scl     = 1'b0;
                                end else begin
                                    n_phase = PH_P0;
                                    n_scl   = 1'b0;
                                    n_sda   = 1'b0;
                                    n_drive = 1'b1;
                                end
                            end
                            PH_R0A: begin
                                n_phase = PH_R0B;
                            end
                            PH_R0B: begin
                                n_phase = PH_R1A;
                                n_scl   = 1'b1;
                            end
                            PH_R1A: begin
                                n_phase = PH_R1B;
                            end
                            PH_R1B: begin
                                n_shift = rx_shift;
                                n_bit   = bit_inc;
                                if (bit_inc < IMT_BITS_PER_BYTE) begin
                                    n_phase = PH_R0A;
                                    n_scl   = 1'b0;
                                end else begin
                                    n_last_read  = rx_shift;
                                    n_read_valid = 1'b1;
                                    n_bytepos    = byte_inc;
                                    n_phase      = PH_Q0;
                                    n_scl        = 1'b0;
                                    n_sda        = (byte_inc >= r_target);
                                    n_drive      = 1'b1;
                                end
                            end
                            PH_Q0: begin
                                n_phase = PH_Q1;
                                n_scl   = 1'b1;
                            end
                            PH_Q1: begin
                                if (r_bytepos >= r_target) begin
                                    n_phase = PH_P0;
                                    n_scl   = 1'b0;
                                    n_sda   = 1'b0;
                                    n_drive = 1'b1;
                                end else begin
                                    n_bit   = 4'd0;
                                    n_shift = 8'd0;
                                    n_phase = PH_R0A;
                                    n_scl   = 1'b0;
                                    n_drive = 1'b0;
                                end
                            end
                            PH_P0: begin
                                n_phase = PH_P1;
                                n_scl   = 1'b1;
                            end
                            PH_P1: begin
                                n_scl   = 1'b1;
                                n_sda   = 1'b1;
                                n_drive = 1'b1;
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                                if (!r_reading) begin
                                    n_fill = '0;
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end else begin
                case (i_op.kind)
                    CMD_LOAD: begin
                        if (r_fill < DEPTH_F) begin
                            store_we = 1'b1;
                            n_fill   = r_fill + FW'(1);
                        end
                    end
                    CMD_WRITE, CMD_READ: begin
                        n_reading = (i_op.kind == CMD_READ);
                        n_addr    = i_op.address;
                        if ((i_op.kind == CMD_READ) || (i_op.byte_count < fill_ext)) begin
                            n_target = i_op.byte_count;
                        end else begin
                            n_target = fill_ext;
                        end
                        n_bytepos = 8'd0;
                        n_bit     = 4'd0;
                        n_shift   = 8'd0;
                        n_unit    = 8'd0;
                        n_nack    = 1'b0;
                        n_phase   = PH_S0;
                        n_scl     = 1'b1;
                        n_sda     = 1'b1;
                        n_drive   = 1'b1;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // Result seen after this request has been applied.
    always_comb begin
        n_res.scl_out    = n_scl;
        n_res.sda_out    = n_drive ? n_sda : 1'b1;
        n_res.sda_drive  = n_drive;
        n_res.read_byte  = n_last_read;
        n_res.read_valid = n_read_valid;
        n_res.busy_res   = (n_phase != PH_IDLE);
        n_res.nack_abort = n_nack;
        n_res.done_res   = n_done;
    end

    // Write buffer; the read port is registered and follows the byte position.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_fill[AW-1:0]] <= i_op.write_byte;
        end
        r_rd_data <= r_store[r_bytepos[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= IMT_UNIT_TICKS_RESET;
            r_phase      <= PH_IDLE;
            r_bit        <= 4'd0;
            r_bytepos    <= 8'd0;
            r_shift      <= 8'd0;
            r_unit       <= 8'd0;
            r_fill       <= '0;
            r_addr       <= 8'd0;
            r_target     <= 8'd0;
            r_reading    <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_drive      <= 1'b1;
            r_last_read  <= 8'd0;
            r_nack       <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_unit_ticks <= i_cfg_wdata;
            end
            r_phase     <= n_phase;
            r_bit       <= n_bit;
            r_bytepos   <= n_bytepos;
            r_shift     <= n_shift;
            r_unit      <= n_unit;
            r_fill      <= n_fill;
            r_addr      <= n_addr;
            r_target    <= n_target;
            r_reading   <= n_reading;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_drive     <= n_drive;
            r_last_read <= n_last_read;
            r_nack      <= n_nack;
            if (take) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

[hdl/imt_checker.sv]
// ============================================================================
// I2C master transaction unit - port checker
// Watches the result channel for handshake and bus-level consistency.
// ============================================================================
`include "i2c_master_transaction_unit_macros.svh"

module imt_checker
    import imt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_res_valid,
    input logic i_res_ready,
    input t_res i_res
);

    // A stalled result stays put.
    `IMT_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res), "result changed while stalled")

    // Completing STOP leaves the bus idle with both lines high.
    `IMT_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, i_res_valid && i_res.done_res, i_res.scl_out && i_res.sda_out && i_res.sda_drive && !i_res.busy_res, "STOP completion with bus not idle")

    // A result that carries a received byte shows the master driving the answer slot.
    `IMT_ASSERT_NOW(a_rx_answer, i_clk, i_rst_n, i_res_valid && i_res.read_valid, i_res.busy_res && !i_res.scl_out && i_res.sda_drive && !i_res.done_res, "read byte without answer slot")

    // Released SDA reads back as high.
    `IMT_ASSERT_NOW(a_release_high, i_clk, i_rst_n, i_res_valid && !i_res.sda_drive, i_res.sda_out && i_res.busy_res, "released SDA not high")

endmodule

bind i2c_master_transaction_unit imt_checker u_imt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .i_res       (o_res)
);

[sim/tb.sv]
// ============================================================================
// I2C master transaction unit - testbench
// Drives command and tick requests into the unit and checks every result
// against a cycle-free model of the bus sequencer. A short table of opening
// requests comes first, then stages of random transactions, each with its own
// delay-unit setting and its own mix of sender gaps and receiver stalls.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import imt_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int REPORT_LIMIT = 10;
    localparam int STAGE_COUNT  = 6;

    // Results that can be read off at a glance: the idle bus after reset, and
    // the bus right after a start, when all lines are still high.
    localparam t_res RES_IDLE    = '{1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam t_res RES_STARTED = '{1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0};

    // One row of the opening table. Where fixed is set, res is the result
    // that must come back; otherwise the bus model supplies it.
    typedef struct packed {
        t_req req;
        logic fixed;
        t_res res;
    } t_row;

    // One stage of the random run. A negative unit leaves the delay-unit
    // register as it is.
    typedef struct packed {
        int unit;
        int gap_pct;
        int stall_pct;
        int items;
    } t_stage;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_req_valid = 1'b0;
    logic       o_req_ready;
    t_req       i_req       = '0;
    logic       o_res_valid;
    logic       i_res_ready = 1'b0;
    t_res       o_res;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = 8'h00;

    // Copy of the unit's state, advanced once per accepted request.
    t_phase     ph       = PH_IDLE;
    logic [7:0] unit_cfg = IMT_UNIT_TICKS_RESET;
    logic [3:0] bit_pos  = '0;
    logic [7:0] byte_pos = '0;
    logic [7:0] shreg    = '0;
    logic [7:0] tick_cnt = '0;
    logic [7:0] wbuf [IMT_BUFFER_DEPTH];
    int         fill     = 0;
    logic [7:0] addr_q   = '0;
    logic [7:0] target   = '0;
    logic       rd_mode  = 1'b0;
    logic       scl_q    = 1'b1;
    logic       sda_q    = 1'b1;
    logic       drv_q    = 1'b1;
    logic       nack_q   = 1'b0;
    logic [7:0] rx_last  = '0;

    // Results still owed by the unit, oldest first.
    t_res results_due [$];

    int mismatch_count = 0;
    int checked        = 0;
    int cycle_count    = 0;
    int gap_pct        = 0;
    int stall_pct      = 0;

    // Request generator state: bytes still to load before the next start, and
    // whether the running transaction should see a NACK on its address.
    int   loads_to_go    = 0;
    logic addr_nack_plan = 1'b0;

    // The opening table works at one tick per delay unit, the reset value.
    // It starts a write with a count larger than the buffer, so the count is
    // cut to the three loaded bytes, and it then steps the bus through START
    // and into the address byte. The random run picks up that transaction.
    t_row opening_rows [21] = '{
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, RES_IDLE},
        '{'{CMD_TICK,  8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, RES_IDLE},
        '{'{CMD_LOAD,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, RES_IDLE},
        '{'{CMD_LOAD,  8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, RES_IDLE},
        '{'{CMD_LOAD,  8'h5A, 8'h80, 8'hA5, 1'b0}, 1'b1, RES_IDLE},
        '{'{CMD_WRITE, 8'hFF, 8'hFF, 8'h3C, 1'b1}, 1'b1, RES_STARTED},
        '{'{CMD_LOAD,  8'h00, 8'h00, 8'h77, 1'b0}, 1'b1, RES_STARTED},
        '{'{CMD_READ,  8'h01, 8'h01, 8'h00, 1'b1}, 1'b1, RES_STARTED},
        '{'{CMD_WRITE, 8'h80, 8'h7F, 8'h01, 1'b0}, 1'b1, RES_STARTED},
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_TICK,  8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, '0}
    };

    // Stages of the random run. A delay unit of zero must act as one tick.
    // The last stage uses the longest unit and is not drained, since a whole
    // transaction would take thousands of ticks; it only has to cross a few
    // unit boundaries.
    t_stage stages [STAGE_COUNT] = '{
        '{-1,   0,  0, 150},
        '{ 0,  52,  0, 150},
        '{ 2,   0, 52, 150},
        '{ 1,  20, 20, 150},
        '{ 3,  52,  0, 100},
        '{255, 20, 20, 600}
    };

    i2c_master_transaction_unit #(
        .BUFFER_DEPTH(IMT_BUFFER_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bus model
    // ------------------------------------------------------------------------

    // Shift a byte out, MSB first. SCL goes low; SDA keeps its level until
    // the first bit is put on the line.
    function automatic void begin_send(input logic [7:0] value);
        shreg   = value;
        bit_pos = '0;
        ph      = PH_B0;
        scl_q   = 1'b0;
    endfunction

    // Release SDA and clock in a byte from the device.
    function automatic void begin_receive();
        bit_pos = '0;
        shreg   = '0;
        ph      = PH_R0A;
        scl_q   = 1'b0;
        drv_q   = 1'b0;
    endfunction

    // SDA low under a low SCL, so that the rising SDA after it is a STOP.
    function automatic void begin_stop();
        ph    = PH_P0;
        scl_q = 1'b0;
        sda_q = 1'b0;
        drv_q = 1'b1;
    endfunction

    // The master answers a received byte: ACK while more bytes are wanted,
    // NACK once the count has been reached.
    function automatic void begin_answer();
        ph    = PH_Q0;
        scl_q = 1'b0;
        sda_q = (byte_pos >= target);
        drv_q = 1'b1;
    endfunction

    // Applies one request to the model and returns the result it must give.
    function automatic t_res predict_bus(input t_req r);
        t_res       res;
        logic       got_byte;
        logic       stop_done;
        logic [7:0] lim;
        got_byte  = 1'b0;
        stop_done = 1'b0;
        if (ph != PH_IDLE) begin
            // Only ticks move bus time; every other command is dropped.
            if (r.command == CMD_TICK) begin
                lim = (unit_cfg == 8'd0) ? 8'd1 : unit_cfg;
                tick_cnt++;
                if (tick_cnt >= lim) begin
                    tick_cnt = '0;
                    case (ph)
                        PH_S0: begin
                            ph    = PH_S1;
                            sda_q = 1'b0;
                        end
                        PH_S1: begin
                            ph    = PH_S2;
                            scl_q = 1'b0;
                        end
                        PH_S2: begin_send(addr_q);
                        PH_B0: begin
                            ph    = PH_B1;
                            drv_q = 1'b1;
                            sda_q = shreg[7];
                        end
                        PH_B1: begin
                            ph    = PH_B2;
                            scl_q = 1'b1;
                        end
                        PH_B2: begin
                            shreg = shreg << 1;
                            bit_pos++;
                            scl_q = 1'b0;
                            ph    = (bit_pos >= IMT_BITS_PER_BYTE) ? PH_A0 : PH_B0;
                        end
                        PH_A0: begin
                            ph    = PH_A1;
                            drv_q = 1'b0;
                        end
                        PH_A1: begin
                            ph    = PH_A2;
                            scl_q = 1'b1;
                        end
                        PH_A2: ph = PH_A3;
                        PH_A3: begin
                            // The device's acknowledge is sampled here.
                            if (r.sda_in) nack_q = 1'b1;
                            ph    = PH_A4;
                            scl_q = 1'b0;
                        end
                        PH_A4: begin
                            ph    = PH_A5;
                            scl_q = 1'b0;
                            sda_q = 1'b0;
                            drv_q = 1'b1;
                        end
                        PH_A5: begin
                            if (nack_q) begin
                                begin_stop();
                            end else if (rd_mode) begin
                                if (byte_pos >= target) begin_answer();
                                else begin_receive();
                            end else if (byte_pos < target && byte_pos < fill) begin
                                begin_send(wbuf[byte_pos]);
                                byte_pos++;
                            end else begin
                                begin_stop();
                            end
                        end
                        PH_R0A: ph = PH_R0B;
                        PH_R0B: begin
                            ph    = PH_R1A;
                            scl_q = 1'b1;
                        end
                        PH_R1A: ph = PH_R1B;
                        PH_R1B: begin
                            shreg = {shreg[6:0], r.sda_in};
                            bit_pos++;
                            if (bit_pos < IMT_BITS_PER_BYTE) begin
                                ph    = PH_R0A;
                                scl_q = 1'b0;
                            end else begin
                                rx_last  = shreg;
                                got_byte = 1'b1;
                                byte_pos++;
                                begin_answer();
                            end
                        end
                        PH_Q0: begin
                            ph    = PH_Q1;
                            scl_q = 1'b1;
                        end
                        PH_Q1: begin
                            if (byte_pos >= target) begin_stop();
                            else begin_receive();
                        end
                        PH_P0: begin
                            ph    = PH_P1;
                            scl_q = 1'b1;
                        end
                        PH_P1: begin
                            scl_q     = 1'b1;
                            sda_q     = 1'b1;
                            drv_q     = 1'b1;
                            ph        = PH_IDLE;
                            stop_done = 1'b1;
                            // Any write, aborted or not, empties the buffer.
                            if (!rd_mode) fill = 0;
                        end
                        default: ph = PH_IDLE;
                    endcase
                end
            end
        end else if (r.command == CMD_LOAD) begin
            // A load into a full buffer is dropped.
            if (fill < IMT_BUFFER_DEPTH) begin
                wbuf[fill] = r.write_byte;
                fill++;
            end
        end else if (r.command == CMD_WRITE || r.command == CMD_READ) begin
            rd_mode  = (r.command == CMD_READ);
            addr_q   = rd_mode ? (r.device_address | IMT_READ_BIT)
                               : (r.device_address & IMT_ADDR_MASK);
            // A write never sends more bytes than it has loaded.
            target   = (rd_mode || r.byte_count < fill) ? r.byte_count : 8'(fill);
            byte_pos = '0;
            bit_pos  = '0;
            shreg    = '0;
            tick_cnt = '0;
            nack_q   = 1'b0;
            ph       = PH_S0;
            scl_q    = 1'b1;
            sda_q    = 1'b1;
            drv_q    = 1'b1;
        end
        res.scl_out    = scl_q;
        res.sda_out    = drv_q ? sda_q : 1'b1;
        res.sda_drive  = drv_q;
        res.read_byte  = rx_last;
        res.read_valid = got_byte;
        res.busy_res   = (ph != PH_IDLE);
        res.nack_abort = nack_q;
        res.done_res   = stop_done;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------------

    // Builds the next random request from the model's present state. Most
    // traffic is well formed: a few loads, a start, then ticks until STOP.
    // All fields start out random so that every bit toggles; a small share
    // of dropped commands during a transaction and idle ticks is kept as
    // noise.
    function automatic t_req next_req();
        t_req        r;
        logic [31:0] noise;
        noise = $urandom;
        r     = noise[$bits(t_req)-1:0];
        if (ph != PH_IDLE) begin
            if ($urandom_range(99) >= 6) r.command = CMD_TICK;
            // In the acknowledge slot keep SDA mostly low so that transfers
            // run deep; a planned address NACK keeps long reads short.
            if (r.command == CMD_TICK && ph == PH_A3)
                r.sda_in = (addr_nack_plan && byte_pos == 8'd0) || ($urandom_range(99) < 8);
        end else if ($urandom_range(99) < 8) begin
            r.command = CMD_TICK;
        end else if (loads_to_go > 0) begin
            loads_to_go--;
            r.command = CMD_LOAD;
        end else begin
            addr_nack_plan = 1'b0;
            if ($urandom_range(99) < 60) begin
                r.command = CMD_WRITE;
                // Mostly a count near the buffer fill, now and then any count.
                if ($urandom_range(5) != 0) r.byte_count = 8'($urandom_range(fill + 1));
            end else begin
                r.command = CMD_READ;
                // Large read counts are allowed only with an address NACK;
                // the rest of the reads are short, zero bytes included.
                if ($urandom_range(4) == 0) addr_nack_plan = (r.byte_count > 8'd6);
                else r.byte_count = 8'($urandom_range(3));
            end
            // Now and then load past the buffer depth so that loads get dropped.
            loads_to_go = ($urandom_range(7) == 0) ? $urandom_range(20, 15)
                                                   : $urandom_range(4);
        end
        return r;
    endfunction

    // Presents one request, waits for the handshake, and records the result
    // it must produce. A random gap may come first; valid is lowered only at
    // the edge that accepted the previous request, so it never drops and
    // rises again in one step.
    task automatic send_req(input t_req r, input logic fixed, input t_res fixed_res);
        t_res want;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            i_req_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_req       <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        want = predict_bus(r);
        results_due.push_back(fixed ? fixed_res : want);
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    function automatic string show_res(input t_res v);
        return $sformatf("scl=%b sda=%b drive=%b byte=%h valid=%b busy=%b nack=%b done=%b",
                         v.scl_out, v.sda_out, v.sda_drive, v.read_byte, v.read_valid,
                         v.busy_res, v.nack_abort, v.done_res);
    endfunction

    function automatic void log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endfunction

    // Results are taken at the edge where valid and ready are both high; the
    // ready for the next edge is drawn after the check.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (results_due.size() == 0) begin
                log_failure($sformatf("result %0d with no request outstanding: %s",
                                      checked, show_res(o_res)));
            end else begin
                want = results_due.pop_front();
                if (o_res !== want)
                    log_failure($sformatf("result %0d expected %s, got %s",
                                          checked, show_res(want), show_res(o_res)));
            end
            checked++;
        end
        i_res_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the unit hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        int n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[k])
            send_req(opening_rows[k].req, opening_rows[k].fixed, opening_rows[k].res);

        for (int s = 0; s < STAGE_COUNT; s++) begin
            // The delay unit is changed only once every owed result is back; since the
            // stage before ran its transaction out to STOP, the unit is then idle.
            if (stages[s].unit >= 0) begin
                while (results_due.size() != 0) @(posedge i_clk);
                i_cfg_we    <= 1'b1;
                i_cfg_wdata <= 8'(stages[s].unit);
                unit_cfg     = 8'(stages[s].unit);
                @(posedge i_clk);
                i_cfg_we    <= 1'b0;
            end
            gap_pct   = stages[s].gap_pct;
            stall_pct = stages[s].stall_pct;
            n = 0;
            // Every stage but the last runs its transaction out to STOP.
            while (n < stages[s].items || (s < STAGE_COUNT - 1 && ph != PH_IDLE)) begin
                send_req(next_req(), 1'b0, '0);
                n++;
            end
            i_req_valid <= 1'b0;
        end

        // Drain, then wait for stray results before reporting.
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
